// File: hdl/ffwp_pkg.sv
// Shared types and constants of the first-fit wave packer.
package ffwp_pkg;

  localparam int MAX_TEAMS_DEF = 64;

  localparam int ID_W    = 16;
  localparam int THR_W   = 11;
  localparam int CORE_W  = 11;
  localparam int USED_W  = 11;
  localparam int TIME_W  = 48;
  localparam int TOTAL_W = 54;
  localparam int WIDX_W  = 6;

  localparam logic [CORE_W-1:0] CORE_COUNT_RST = CORE_W'(64);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_OPEN,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_EM_WAVE_RD,
    ST_EM_WAVE,
    ST_EM_TEAM_RD,
    ST_EM_OUT
  } ffwp_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   team_tag;
    logic [THR_W-1:0]  threads;
    logic [TIME_W-1:0] run_time;
    logic              final_team;
  } ffwp_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    team_tag;
    logic [THR_W-1:0]   threads;
    logic [WIDX_W-1:0]  wave_index;
    logic               wave_end;
    logic [TOTAL_W-1:0] total_time;
    logic               dropped;
    logic               last_result;
  } ffwp_result_t;

endpackage

// File: hdl/ffwp_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module ffwp_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ffwp_seq.sv
// Packing sequencer: wave scan, placement, maxima sum and linked-list emission.
module ffwp_seq import ffwp_pkg::*; #(
  parameter int MAX_TEAMS = MAX_TEAMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CORE_W-1:0] core_count,
  input  logic              item_valid,
  input  ffwp_item_t        item,
  output logic              busy,
  output logic              emit_valid,
  output ffwp_result_t      emit,
  input  logic              emit_take
);

  localparam int IDX_W  = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TEAMS + 1);
  localparam int WAVE_W = 2 * IDX_W + USED_W + TIME_W;
  localparam int TEAM_W = ID_W + THR_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TEAMS);

  ffwp_state_t         state_r, state_nxt;
  ffwp_item_t          item_r, item_nxt;
  logic [CNT_W-1:0]    wave_cnt_r, wave_cnt_nxt;
  logic [CNT_W-1:0]    team_cnt_r, team_cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    t_r, t_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic                wave_we, wave_re;
  logic [IDX_W-1:0]    wave_waddr;
  logic [WAVE_W-1:0]   wave_wdata, wave_rdata;
  logic                team_we, team_re;
  logic [TEAM_W-1:0]   team_rdata;
  logic                next_we;
  logic [IDX_W-1:0]    next_rdata;

  logic [IDX_W-1:0]    rd_head, rd_tail;
  logic [USED_W-1:0]   rd_used;
  logic [TIME_W-1:0]   rd_max;
  logic [USED_W:0]     sum_thr;
  logic                fit;
  logic [TIME_W-1:0]   new_max;
  logic                idx_last;
  logic [IDX_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    tc_idx;
  logic                full;
  logic                is_tail;

  // Per wave: head and tail of its team list, used threads, longest run time.
  ffwp_ram #(.W(WAVE_W), .D(MAX_TEAMS), .AW(IDX_W)) u_wave_ram (
    .clk   (clk),
    .we    (wave_we),
    .waddr (wave_waddr),
    .wdata (wave_wdata),
    .re    (wave_re),
    .raddr (idx_r),
    .rdata (wave_rdata)
  );

  // Per team, in arrival order: identifier and thread count.
  ffwp_ram #(.W(TEAM_W), .D(MAX_TEAMS), .AW(IDX_W)) u_team_ram (
    .clk   (clk),
    .we    (team_we),
    .waddr (tc_idx),
    .wdata ({item_r.team_tag, item_r.threads}),
    .re    (team_re),
    .raddr (t_r),
    .rdata (team_rdata)
  );

  // Per team: the next team of the same wave.
  ffwp_ram #(.W(IDX_W), .D(MAX_TEAMS), .AW(IDX_W)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (rd_tail),
    .wdata (tc_idx),
    .re    (team_re),
    .raddr (t_r),
    .rdata (next_rdata)
  );

  assign rd_head = wave_rdata[WAVE_W-1 -: IDX_W];
  assign rd_tail = wave_rdata[WAVE_W-IDX_W-1 -: IDX_W];
  assign rd_used = wave_rdata[USED_W+TIME_W-1 -: USED_W];
  assign rd_max  = wave_rdata[TIME_W-1:0];

  // The shared compare unit: used threads plus the team against capacity.
  assign sum_thr  = {1'b0, rd_used} + {1'b0, item_r.threads};
  assign fit      = sum_thr <= {1'b0, core_count};
  assign new_max  = (item_r.run_time > rd_max) ? item_r.run_time : rd_max;
  assign idx_last = (CNT_W'(idx_r) + CNT_W'(1)) == wave_cnt_r;
  assign idx_inc  = idx_r + IDX_W'(1);
  assign tc_idx   = team_cnt_r[IDX_W-1:0];
  assign full     = team_cnt_r == FULL_CNT;
  assign is_tail  = t_r == rd_tail;

  always_comb begin
    emit.team_tag    = team_rdata[TEAM_W-1 -: ID_W];
    emit.threads     = team_rdata[THR_W-1:0];
    emit.wave_index  = WIDX_W'(idx_r);
    emit.wave_end    = is_tail;
    emit.last_result = is_tail && idx_last;
    emit.total_time  = (is_tail && idx_last) ? total_r : '0;
    emit.dropped     = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wave_cnt_r <= '0;
      team_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wave_cnt_r <= wave_cnt_nxt;
      team_cnt_r <= team_cnt_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    idx_r   <= idx_nxt;
    t_r     <= t_nxt;
    total_r <= total_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    wave_cnt_nxt = wave_cnt_r;
    team_cnt_nxt = team_cnt_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    t_nxt        = t_r;
    total_nxt    = total_r;
    busy         = 1'b1;
    emit_valid   = 1'b0;
    wave_we      = 1'b0;
    wave_re      = 1'b0;
    wave_waddr   = idx_r;
    wave_wdata   = {rd_head, tc_idx, sum_thr[USED_W-1:0], new_max};
    team_we      = 1'b0;
    team_re      = 1'b0;
    next_we      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (item_valid) begin
          item_nxt  = item;
          total_nxt = '0;
          idx_nxt   = '0;
          if (full) begin
            // The team is discarded; a final team still starts emission.
            ovf_nxt   = 1'b1;
            state_nxt = item.final_team ? ST_SUM_RD : ST_IDLE;
          end else if (wave_cnt_r == '0) begin
            state_nxt = ST_OPEN;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        wave_re   = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (fit) begin
          wave_we      = 1'b1;
          team_we      = 1'b1;
          next_we      = 1'b1;
          team_cnt_nxt = team_cnt_r + CNT_W'(1);
          idx_nxt      = '0;
          state_nxt    = item_r.final_team ? ST_SUM_RD : ST_IDLE;
        end else if (idx_last) begin
          state_nxt = ST_OPEN;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_OPEN: begin
        wave_we      = 1'b1;
        wave_waddr   = wave_cnt_r[IDX_W-1:0];
        wave_wdata   = {tc_idx, tc_idx, item_r.threads, item_r.run_time};
        team_we      = 1'b1;
        wave_cnt_nxt = wave_cnt_r + CNT_W'(1);
        team_cnt_nxt = team_cnt_r + CNT_W'(1);
        idx_nxt      = '0;
        state_nxt    = item_r.final_team ? ST_SUM_RD : ST_IDLE;
      end
      ST_SUM_RD: begin
        wave_re   = 1'b1;
        state_nxt = ST_SUM_ADD;
      end
      ST_SUM_ADD: begin
        total_nxt = total_r + TOTAL_W'(rd_max);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_EM_WAVE_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SUM_RD;
        end
      end
      ST_EM_WAVE_RD: begin
        wave_re   = 1'b1;
        state_nxt = ST_EM_WAVE;
      end
      ST_EM_WAVE: begin
        t_nxt     = rd_head;
        state_nxt = ST_EM_TEAM_RD;
      end
      ST_EM_TEAM_RD: begin
        team_re   = 1'b1;
        state_nxt = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        emit_valid = 1'b1;
        if (emit_take) begin
          if (is_tail) begin
            if (idx_last) begin
              wave_cnt_nxt = '0;
              team_cnt_nxt = '0;
              ovf_nxt      = 1'b0;
              state_nxt    = ST_IDLE;
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = ST_EM_WAVE_RD;
            end
          end else begin
            t_nxt     = next_rdata;
            state_nxt = ST_EM_TEAM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/first_fit_wave_packer.sv
// Top level of the first-fit wave packer: configuration port, result register, sequencer.
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_stall       team_tag, threads, run_time, final_team
//   out_      output     out_valid / out_stall     team, wave, wave_end, total, flags
//   cfg_      input      APB write / read          core_count at byte address 0
//
// A team that joins an open wave is checked against each wave in turn up to the one it
// joins; a team that opens a wave does so after scanning all open waves. A discarded team
// is not scanned. A final team, placed or discarded, then starts the sum of the wave
// maxima, followed by emission wave by wave and team by team, which waits while out_stall
// holds a full result register.
// Reset is synchronous and empties the batch; core_count returns to 64.
// in_stall is high while a team is being placed or the batch is emitted.
module first_fit_wave_packer import ffwp_pkg::*; #(
  parameter int MAX_TEAMS = MAX_TEAMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_team_tag,
  input  logic [THR_W-1:0]   in_threads,
  input  logic [TIME_W-1:0]  in_run_time,
  input  logic               in_final_team,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_team_tag,
  output logic [THR_W-1:0]   out_threads,
  output logic [WIDX_W-1:0]  out_wave_index,
  output logic               out_wave_end,
  output logic [TOTAL_W-1:0] out_total_time,
  output logic               out_dropped,
  output logic               out_last_result,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam logic [2:0] ADDR_CORE_COUNT = 3'd0;

  logic [CORE_W-1:0] core_count_r;
  logic              out_valid_r;
  ffwp_result_t      out_r;
  ffwp_item_t        item;
  ffwp_result_t      emit;
  logic              emit_valid;
  logic              emit_take;
  logic              busy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_CORE_COUNT) ? 32'(core_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r <= CORE_COUNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_CORE_COUNT) begin
      core_count_r <= cfg_pwdata[CORE_W-1:0];
    end
  end

  assign item.team_tag   = in_team_tag;
  assign item.threads    = in_threads;
  assign item.run_time   = in_run_time;
  assign item.final_team = in_final_team;

  ffwp_seq #(.MAX_TEAMS(MAX_TEAMS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .core_count (core_count_r),
    .item_valid (in_valid),
    .item       (item),
    .busy       (busy),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_take  (emit_take)
  );

  assign in_stall = busy;

  // The result register loads whenever it is empty or its transfer completes.
  assign emit_take = emit_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_r <= emit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_team_tag    = out_r.team_tag;
  assign out_threads     = out_r.threads;
  assign out_wave_index  = out_r.wave_index;
  assign out_wave_end    = out_r.wave_end;
  assign out_total_time  = out_r.total_time;
  assign out_dropped     = out_r.dropped;
  assign out_last_result = out_r.last_result;

  a_last_closes_wave: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_wave_end)
    else $error("last result of a batch does not close its wave");

  a_total_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_total_time == '0)
    else $error("total time shown on a result that is not the last");

  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result register holds data after reset");

endmodule

// File: tb/ffwp_checker.sv
// Checker for the first-fit wave packer: predicts emitted teams and compares them.
module ffwp_checker import ffwp_pkg::*; #(
  parameter logic [2:0] CORE_ADDR = 3'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ID_W-1:0]    in_team_tag,
  input  logic [THR_W-1:0]   in_threads,
  input  logic [TIME_W-1:0]  in_run_time,
  input  logic               in_final_team,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ID_W-1:0]    out_team_tag,
  input  logic [THR_W-1:0]   out_threads,
  input  logic [WIDX_W-1:0]  out_wave_index,
  input  logic               out_wave_end,
  input  logic [TOTAL_W-1:0] out_total_time,
  input  logic               out_dropped,
  input  logic               out_last_result,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic [31:0]        cfg_prdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending_count,
  output int                 checked_count
);

  logic [CORE_W-1:0] core_q;
  logic [USED_W-1:0] wave_used_q [MAX_TEAMS_DEF];
  logic [TIME_W-1:0] wave_peak_q [MAX_TEAMS_DEF];
  int                wave_total;
  logic [ID_W-1:0]   team_id_q   [MAX_TEAMS_DEF];
  logic [THR_W-1:0]  team_thr_q  [MAX_TEAMS_DEF];
  logic [WIDX_W-1:0] team_wave_q [MAX_TEAMS_DEF];
  int                team_total;
  logic              overflow_q;

  ffwp_result_t expected_teams [$];
  int errors = 0;
  int checked = 0;

  // First open wave with room takes the team; otherwise a new wave opens.
  task automatic place_team(input logic [ID_W-1:0] id, input logic [THR_W-1:0] thr,
                            input logic [TIME_W-1:0] rt);
    int w;
    if (team_total >= MAX_TEAMS_DEF) begin
      overflow_q = 1'b1;
      return;
    end
    w = 0;
    while (w < wave_total && (int'(wave_used_q[w]) + int'(thr) > int'(core_q)))
      w++;
    if (w == wave_total) begin
      wave_used_q[w] = '0;
      wave_peak_q[w] = '0;
      wave_total++;
    end
    wave_used_q[w] = wave_used_q[w] + thr;
    if (rt > wave_peak_q[w])
      wave_peak_q[w] = rt;
    team_id_q[team_total] = id;
    team_thr_q[team_total] = thr;
    team_wave_q[team_total] = WIDX_W'(w);
    team_total++;
  endtask

  // Emission order is wave by wave, and arrival order inside a wave.
  task automatic release_batch();
    logic [TOTAL_W-1:0] total;
    ffwp_result_t r;
    int n;
    int w;
    int t;
    int u;
    bit closes;
    total = '0;
    n = 0;
    for (w = 0; w < wave_total; w++)
      total += TOTAL_W'(wave_peak_q[w]);
    for (w = 0; w < wave_total; w++) begin
      for (t = 0; t < team_total; t++) begin
        if (team_wave_q[t] == WIDX_W'(w)) begin
          closes = 1'b1;
          for (u = t + 1; u < team_total; u++)
            if (team_wave_q[u] == team_wave_q[t])
              closes = 1'b0;
          n++;
          r.team_tag = team_id_q[t];
          r.threads = team_thr_q[t];
          r.wave_index = WIDX_W'(w);
          r.wave_end = closes;
          r.last_result = (n == team_total);
          r.total_time = r.last_result ? total : '0;
          r.dropped = overflow_q;
          expected_teams.insert(expected_teams.size(), r);
        end
      end
    end
    wave_total = 0;
    team_total = 0;
    overflow_q = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    ffwp_result_t seen;
    ffwp_result_t want;
    if (!rst_n) begin
      core_q = CORE_COUNT_RST;
      wave_total = 0;
      team_total = 0;
      overflow_q = 1'b0;
      expected_teams.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.team_tag = out_team_tag;
        seen.threads = out_threads;
        seen.wave_index = out_wave_index;
        seen.wave_end = out_wave_end;
        seen.total_time = out_total_time;
        seen.dropped = out_dropped;
        seen.last_result = out_last_result;
        if (expected_teams.size() == 0) begin
          $display("%0t: result transfer with nothing expected: tag=%h wave=%0d",
                   $time, out_team_tag, out_wave_index);
          errors++;
        end else begin
          want = expected_teams.pop_front();
          checked++;
          if (seen !== want) begin
            $display("%0t: mismatch, expected tag=%h thr=%0d wave=%0d end=%b total=%0d ",
                     $time, want.team_tag, want.threads, want.wave_index, want.wave_end,
                     want.total_time,
                     "drop=%b last=%b; actual tag=%h thr=%0d wave=%0d end=%b total=%0d ",
                     want.dropped, want.last_result, seen.team_tag, seen.threads,
                     seen.wave_index, seen.wave_end, seen.total_time,
                     "drop=%b last=%b", seen.dropped, seen.last_result);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        place_team(in_team_tag, in_threads, in_run_time);
        if (in_final_team)
          release_batch();
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == CORE_ADDR) begin
        if (cfg_pwrite) begin
          core_q = cfg_pwdata[CORE_W-1:0];
        end else if (cfg_prdata[CORE_W-1:0] !== core_q) begin
          $display("%0t: core_count read mismatch, expected %0d, actual %0d",
                   $time, core_q, cfg_prdata[CORE_W-1:0]);
          errors++;
        end
      end
    end
    fail_count <= errors;
    pending_count <= expected_teams.size();
    checked_count <= checked;
  end

endmodule

// File: tb/tb_first_fit_wave_packer.sv
// Testbench top of the first-fit wave packer: clock, reset, stimulus and verdict.
module tb_first_fit_wave_packer;
  import ffwp_pkg::*;

  localparam logic [2:0]        CORE_ADDR     = 3'd0;
  localparam int                CYCLE_LIMIT   = 1_000_000;
  localparam int                SETTLE_CYCLES = 400;
  localparam int                RANDOM_TEAMS  = 480;
  localparam int                THR_TOP       = 2047;
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam logic [ID_W-1:0]   ID_MAX        = '1;

  typedef enum int {MIX_SMALL, MIX_NEAR, MIX_ANY, MIX_SOLO} team_mix_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ID_W-1:0]    in_team_tag;
  logic [THR_W-1:0]   in_threads;
  logic [TIME_W-1:0]  in_run_time;
  logic               in_final_team;
  logic               out_valid;
  logic               out_stall;
  logic [ID_W-1:0]    out_team_tag;
  logic [THR_W-1:0]   out_threads;
  logic [WIDX_W-1:0]  out_wave_index;
  logic               out_wave_end;
  logic [TOTAL_W-1:0] out_total_time;
  logic               out_dropped;
  logic               out_last_result;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  int fail_count;
  int pending_count;
  int checked_count;

  int cur_core = 64;
  int teams_sent = 0;
  int batches_sent = 0;
  int core_writes = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  first_fit_wave_packer dut (.*);

  ffwp_checker #(.CORE_ADDR(CORE_ADDR)) packer_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("first_fit_wave_packer verification failed");
      $finish;
    end
  end

  // Receiver stalls: mostly short, a few long, with free-running stretches between.
  initial begin
    int r;
    int len;
    out_stall <= 1'b0;
    forever begin
      r = $urandom_range(99);
      if (r < 40) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 30);
      end else if (r < 80) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        len = $urandom_range(4, 10);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps)
      return 0;
    r = $urandom_range(99);
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(9);
    if (r == 0)
      return '0;
    if (r == 1)
      return TIME_MAX;
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(19);
    if (r == 0)
      return '0;
    if (r == 1)
      return ID_MAX;
    return ID_W'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_threads(input team_mix_t mix);
    int lo;
    int hi;
    case (mix)
      MIX_SMALL: return $urandom_range(0, cur_core / 4 + 1);
      MIX_NEAR: begin
        if ($urandom_range(3) == 0)
          return cur_core / 2;
        lo = (cur_core > 3) ? cur_core - 3 : 0;
        hi = (cur_core + 3 > THR_TOP) ? THR_TOP : cur_core + 3;
        return $urandom_range(lo, hi);
      end
      MIX_ANY: return $urandom_range(0, THR_TOP);
      default: return THR_TOP;
    endcase
  endfunction

  // Returns at the edge where the team transfer completes; in_valid is left high.
  task automatic send_team(input logic [ID_W-1:0] id, input int thr,
                           input logic [TIME_W-1:0] rt, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_team_tag <= id;
    in_threads <= THR_W'(thr);
    in_run_time <= rt;
    in_final_team <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    teams_sent++;
  endtask

  task automatic drain_packer();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called between batches, once the packer has gone quiet.
  task automatic write_core(input int value);
    drain_packer();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CORE_ADDR;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cur_core = value;
    core_writes++;
  endtask

  task automatic run_batch(input int count, input team_mix_t mix, input bit peak_times);
    int i;
    for (i = 0; i < count; i++)
      send_team(pick_id(), pick_threads(mix), peak_times ? TIME_MAX : pick_time(),
                i == count - 1);
    batches_sent++;
  endtask

  initial begin
    int random_start;
    int r;
    int count;
    team_mix_t mix;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_team_tag <= '0;
    in_threads <= '0;
    in_run_time <= '0;
    in_final_team <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity of 64: a lone final team, then a batch with a full wave,
    // zero-thread teams, an oversized team and an exact refill of a wave.
    send_team('0, 1, '0, 1'b1);
    send_team(ID_MAX, 64, TIME_MAX, 1'b0);
    send_team(16'h1234, 1, 48'd5, 1'b0);
    send_team(16'h0001, 0, 48'd7, 1'b0);
    send_team(16'hABCD, THR_TOP, 48'd1, 1'b0);
    send_team(16'h0002, 1024, 48'd2, 1'b0);
    send_team(16'h0003, 63, 48'd3, 1'b0);
    send_team(16'h0004, 0, TIME_MAX, 1'b1);
    batches_sent += 2;

    // Zero capacity: only zero-thread teams share a wave.
    write_core(0);
    send_team(16'h0010, 0, 48'd9, 1'b0);
    send_team(16'h0011, 0, 48'd8, 1'b0);
    send_team(16'h0012, 1, 48'd7, 1'b0);
    send_team(16'h0013, 1, 48'd6, 1'b1);
    batches_sent++;

    write_core(THR_TOP);
    send_team(16'h0020, THR_TOP, 48'd100, 1'b0);
    send_team(16'h0021, 0, 48'd50, 1'b0);
    send_team(16'h0022, 1, 48'd60, 1'b0);
    send_team(16'h0023, THR_TOP - 1, 48'd70, 1'b1);
    batches_sent++;

    write_core(1);
    send_team(16'h0030, 1, 48'd1, 1'b0);
    send_team(16'h0031, 1, 48'd2, 1'b0);
    send_team(16'h0032, 0, 48'd3, 1'b1);
    batches_sent++;

    // A full store of single-team waves at peak time, with the last two teams, the final one among them, dropped.
    random_start = teams_sent;
    write_core(1024);
    run_batch(MAX_TEAMS_DEF + 2, MIX_SOLO, 1'b1);

    while (teams_sent - random_start < RANDOM_TEAMS) begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(7))
          0: write_core(0);
          1: write_core(1);
          2: write_core(2);
          3: write_core(64);
          4: write_core(1023);
          5: write_core(1024);
          6: write_core(THR_TOP);
          default: write_core($urandom_range(1, 1024));
        endcase
      end
      no_gaps = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 70)
        count = $urandom_range(1, 10);
      else if (r < 90)
        count = $urandom_range(11, 40);
      else
        count = $urandom_range(MAX_TEAMS_DEF - 2, MAX_TEAMS_DEF + 6);
      mix = team_mix_t'($urandom_range(3));
      run_batch(count, mix, mix == MIX_SOLO && $urandom_range(1) == 1);
    end

    no_gaps = 1'b0;
    drain_packer();
    $display("Sent %0d teams in %0d batches across %0d core_count writes.",
             teams_sent, batches_sent, core_writes);
    $display("Checked %0d emitted teams against the predicted first-fit packing.",
             checked_count);
    if (fail_count == 0) begin
      $display("first_fit_wave_packer verification clean");
    end else begin
      $display("first_fit_wave_packer verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ffwp_pkg.sv
hdl/ffwp_ram.sv
hdl/ffwp_seq.sv
hdl/first_fit_wave_packer.sv
tb/ffwp_checker.sv
tb/tb_first_fit_wave_packer.sv
